// ===== rtl/vcf_pkg.sv =====
// Shared types, constants and binary32 arithmetic helpers for the vector cosine core.
package vcf_pkg;

  localparam int LANES = 8;
  localparam int NSTEP = 21;
  localparam int LAT   = 2 * NSTEP;

  localparam logic [31:0] MAG_MASK  = 32'h7FFF_FFFF;
  localparam logic [31:0] ARG_LIMIT = 32'h4A98_9680;
  localparam logic [31:0] FLAG_FILL = 32'h7FC0_0000;

  localparam logic [31:0] K_HALF_PI = 32'h3FC9_0FDB;
  localparam logic [31:0] K_INV_PI  = 32'h3EA2_F983;
  localparam logic [31:0] K_SHIFT   = 32'h4B40_0000;
  localparam logic [31:0] K_NSHIFT  = 32'hCB40_0000;
  localparam logic [31:0] K_NHALF   = 32'hBF00_0000;
  localparam logic [31:0] K_PI_HI   = 32'hC049_0FDB;
  localparam logic [31:0] K_PI_MID  = 32'h33BB_BD2E;
  localparam logic [31:0] K_PI_LO   = 32'h2777_2CED;
  localparam logic [31:0] K_C0      = 32'h3F80_0000;
  localparam logic [31:0] K_C1      = 32'hBE2A_AAA4;
  localparam logic [31:0] K_C2      = 32'h3C08_86FA;
  localparam logic [31:0] K_C3      = 32'hB94F_A175;
  localparam logic [31:0] K_C4      = 32'h362D_973B;

  typedef enum logic {OP_ADD, OP_MUL} op_t;
  typedef enum logic [2:0] {SRC_A, SRC_T, SRC_F, SRC_F2, SRC_P, SRC_K} src_t;
  typedef enum logic [2:0] {DST_T, DST_TP, DST_F, DST_F2, DST_P} dst_t;

  typedef struct packed {
    op_t         op;
    src_t        sa;
    src_t        sb;
    logic [31:0] k;
    dst_t        dst;
  } step_t;

  // Operation sequence of one lane: reduction, then the Horner polynomial
  localparam step_t STEPS [NSTEP] = '{
    '{OP_ADD, SRC_A,  SRC_K,  K_HALF_PI, DST_T},
    '{OP_MUL, SRC_T,  SRC_K,  K_INV_PI,  DST_T},
    '{OP_ADD, SRC_T,  SRC_K,  K_SHIFT,   DST_TP},
    '{OP_ADD, SRC_T,  SRC_K,  K_NSHIFT,  DST_T},
    '{OP_ADD, SRC_T,  SRC_K,  K_NHALF,   DST_T},
    '{OP_MUL, SRC_T,  SRC_K,  K_PI_HI,   DST_P},
    '{OP_ADD, SRC_A,  SRC_P,  K_C0,      DST_F},
    '{OP_MUL, SRC_T,  SRC_K,  K_PI_MID,  DST_P},
    '{OP_ADD, SRC_F,  SRC_P,  K_C0,      DST_F},
    '{OP_MUL, SRC_T,  SRC_K,  K_PI_LO,   DST_P},
    '{OP_ADD, SRC_F,  SRC_P,  K_C0,      DST_F},
    '{OP_MUL, SRC_F,  SRC_F,  K_C0,      DST_F2},
    '{OP_MUL, SRC_F2, SRC_K,  K_C4,      DST_P},
    '{OP_ADD, SRC_P,  SRC_K,  K_C3,      DST_P},
    '{OP_MUL, SRC_P,  SRC_F2, K_C0,      DST_P},
    '{OP_ADD, SRC_P,  SRC_K,  K_C2,      DST_P},
    '{OP_MUL, SRC_P,  SRC_F2, K_C0,      DST_P},
    '{OP_ADD, SRC_P,  SRC_K,  K_C1,      DST_P},
    '{OP_MUL, SRC_P,  SRC_F2, K_C0,      DST_P},
    '{OP_ADD, SRC_P,  SRC_K,  K_C0,      DST_P},
    '{OP_MUL, SRC_F,  SRC_P,  K_C0,      DST_P}
  };

  // Exact intermediate: value = mag * 2^k
  typedef struct packed {
    logic               sign;
    logic [49:0]        mag;
    logic signed [10:0] k;
  } raw_t;

  // Per-lane context carried alongside the arithmetic
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] t;
    logic [31:0] f;
    logic [31:0] f2;
    logic [31:0] p;
    logic        par;
    logic        flag;
  } ctx_t;

  function automatic logic [31:0] pick(ctx_t c, src_t s, logic [31:0] k);
    logic [31:0] v;
    case (s)
      SRC_A:   v = c.a;
      SRC_T:   v = c.t;
      SRC_F:   v = c.f;
      SRC_F2:  v = c.f2;
      SRC_P:   v = c.p;
      default: v = k;
    endcase
    return v;
  endfunction

  // Align and add/subtract exactly, with the shifted-out bits jammed into bit 0
  function automatic raw_t fp_add_pre(logic [31:0] a, logic [31:0] b);
    logic [31:0] x;
    logic [31:0] y;
    logic [7:0]  ex;
    logic [7:0]  ey;
    logic [23:0] mx;
    logic [23:0] my;
    logic [49:0] wx;
    logic [49:0] wy;
    logic [49:0] sh;
    logic [49:0] lm;
    logic        st;
    int          d;
    raw_t        r;
    if (a[30:0] >= b[30:0]) begin
      x = a;
      y = b;
    end else begin
      x = b;
      y = a;
    end
    ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
    mx = {|x[30:23], x[22:0]};
    my = {|y[30:23], y[22:0]};
    d  = int'(ex) - int'(ey);
    if (d > 50) d = 50;
    wx = {1'b0, mx, 25'd0};
    wy = {1'b0, my, 25'd0};
    sh = wy >> d;
    lm = (50'(1) << d) - 50'(1);
    st = |(wy & lm);
    if (x[31] == y[31]) r.mag = wx + (sh | 50'(st));
    else                r.mag = wx - (sh | 50'(st));
    r.sign = (r.mag == 50'd0) ? (x[31] & y[31]) : x[31];
    r.k    = 11'(int'(ex) - 175);
    return r;
  endfunction

  // Exact significand product
  function automatic raw_t fp_mul_pre(logic [31:0] a, logic [31:0] b);
    logic [7:0]  ea;
    logic [7:0]  eb;
    logic [23:0] ma;
    logic [23:0] mb;
    raw_t        r;
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma = {|a[30:23], a[22:0]};
    mb = {|b[30:23], b[22:0]};
    r.sign = a[31] ^ b[31];
    r.mag  = {2'b00, 48'(ma) * 48'(mb)};
    r.k    = 11'(int'(ea) + int'(eb) - 300);
    return r;
  endfunction

  // Normalize and round to nearest even, subnormals kept
  function automatic logic [31:0] fp_round(raw_t r);
    int          p;
    int          e;
    int          s;
    logic [49:0] mn;
    logic [49:0] lm;
    logic        ext;
    logic        g;
    logic        st;
    logic        inc;
    logic [22:0] frac;
    logic [7:0]  ef;
    logic [30:0] pk;
    logic [31:0] res;
    p = 0;
    for (int i = 0; i < 50; i++) begin
      if (r.mag[i]) p = i;
    end
    e   = p + int'(r.k) + 127;
    mn  = r.mag << (49 - p);
    ext = 1'b0;
    ef  = 8'(e);
    if (e < 1) begin
      s = 1 - e;
      if (s > 50) s = 50;
      lm  = (50'(1) << s) - 50'(1);
      ext = |(mn & lm);
      mn  = mn >> s;
      ef  = 8'd0;
    end
    frac = mn[48:26];
    g    = mn[25];
    st   = (|mn[24:0]) | ext;
    inc  = g & (st | frac[0]);
    pk   = {ef, frac} + 31'(inc);
    if (r.mag == 50'd0)  res = {r.sign, 31'd0};
    else if (e >= 255)   res = {r.sign, 8'hFF, 23'd0};
    else                 res = {r.sign, pk};
    return res;
  endfunction

endpackage

// ===== rtl/vcf_if.sv =====
// Valid/ready channel interfaces for the vector cosine core.
interface vcf_in_if #(parameter int LANES = vcf_pkg::LANES);
  logic                   valid;
  logic                   ready;
  logic [LANES-1:0][31:0] x;
  modport source (output valid, output x, input ready);
  modport sink   (input valid, input x, output ready);
endinterface

interface vcf_out_if #(parameter int LANES = vcf_pkg::LANES);
  logic                   valid;
  logic                   ready;
  logic [LANES-1:0][31:0] y;
  logic [LANES-1:0]       out_of_range_mask;
  modport source (output valid, output y, output out_of_range_mask, input ready);
  modport sink   (input valid, input y, input out_of_range_mask, output ready);
endinterface

// ===== rtl/vcf_fpu.sv =====
// Two-stage binary32 adder or multiplier: exact combine, then normalize and round.
module vcf_fpu #(
  parameter vcf_pkg::op_t OP = vcf_pkg::OP_ADD
) (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);

  vcf_pkg::raw_t raw_r, raw_nxt;
  logic [31:0]   y_r, y_nxt;

  // Combine operands exactly, then round the registered intermediate
  always_comb begin
    raw_nxt = (OP == vcf_pkg::OP_MUL) ? vcf_pkg::fp_mul_pre(a, b) : vcf_pkg::fp_add_pre(a, b);
    y_nxt   = vcf_pkg::fp_round(raw_r);
  end

  // Advance both stages together
  always_ff @(posedge clk) begin
    if (en) begin
      raw_r <= raw_nxt;
      y_r   <= y_nxt;
    end
  end

  assign y = y_r;

endmodule

// ===== rtl/vcf_lane.sv =====
// One cosine lane: a chain of pipelined float steps with the lane context riding along.
module vcf_lane (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] x,
  output logic [31:0] y,
  output logic        flag
);

  vcf_pkg::ctx_t ctx [vcf_pkg::NSTEP+1];
  vcf_pkg::ctx_t ctx_in;

  // Clear the sign and flag magnitudes beyond the reduction range
  always_comb begin
    ctx_in      = '0;
    ctx_in.a    = x & vcf_pkg::MAG_MASK;
    ctx_in.flag = ctx_in.a > vcf_pkg::ARG_LIMIT;
  end
  assign ctx[0] = ctx_in;

  for (genvar g = 0; g < vcf_pkg::NSTEP; g++) begin : g_step
    localparam vcf_pkg::step_t ST = vcf_pkg::STEPS[g];
    logic [31:0]   opa, opb, res;
    vcf_pkg::ctx_t d1_r, d2_r, upd;

    assign opa = vcf_pkg::pick(ctx[g], ST.sa, ST.k);
    assign opb = vcf_pkg::pick(ctx[g], ST.sb, ST.k);

    vcf_fpu #(.OP(ST.op)) u_fpu (
      .clk (clk),
      .en  (en),
      .a   (opa),
      .b   (opb),
      .y   (res)
    );

    // Delay the context to match the unit's two stages
    always_ff @(posedge clk) begin
      if (en) begin
        d1_r <= ctx[g];
        d2_r <= d1_r;
      end
    end

    // Write the step result into its context field
    always_comb begin
      upd = d2_r;
      case (ST.dst)
        vcf_pkg::DST_TP: begin
          upd.t   = res;
          upd.par = res[0];
        end
        vcf_pkg::DST_F:  upd.f  = res;
        vcf_pkg::DST_F2: upd.f2 = res;
        vcf_pkg::DST_P:  upd.p  = res;
        default:         upd.t  = res;
      endcase
    end
    assign ctx[g+1] = upd;
  end

  // Apply the quadrant sign, or the fill pattern on flagged lanes
  assign flag = ctx[vcf_pkg::NSTEP].flag;
  assign y    = flag ? vcf_pkg::FLAG_FILL
                     : (ctx[vcf_pkg::NSTEP].p ^ {ctx[vcf_pkg::NSTEP].par, 31'd0});

endmodule

// ===== rtl/vector_cosine_float32_core.sv =====
// Top level: parallel cosine lanes, merged result and out-of-range mask.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    x[LANES] float32 bit patterns
//   out_ch   out  valid/ready    y[LANES] float32, out_of_range_mask[LANES]
//
// One item per cycle sustained while the output is not stalled; the latency is set by 21 dependent
// float operations, each a two-stage add or multiply unit.
// Synchronous active-low reset clears the valid pipeline only.
// A stalled output freezes the whole pipeline, input included; the pipeline advances
// whenever the output slot is empty or its item is being taken.
module vector_cosine_float32_core #(
  parameter int LANES = vcf_pkg::LANES
) (
  input  logic       clk,
  input  logic       rst_n,
  vcf_in_if.sink     in_ch,
  vcf_out_if.source  out_ch
);

  localparam int LAT = vcf_pkg::LAT;

  logic [LAT-1:0] vld_r, vld_nxt;
  logic           en;

  wire [LANES-1:0][31:0] lane_y;
  wire [LANES-1:0]       lane_flag;

  // Advance whenever the output slot is empty or being taken
  assign en          = ~vld_r[LAT-1] | out_ch.ready;
  assign in_ch.ready = en;
  assign vld_nxt     = {vld_r[LAT-2:0], in_ch.valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // Lanes side by side, flags merged into one mask
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    vcf_lane u_lane (
      .clk  (clk),
      .en   (en),
      .x    (in_ch.x[i]),
      .y    (lane_y[i]),
      .flag (lane_flag[i])
    );
  end

  assign out_ch.y                 = lane_y;
  assign out_ch.out_of_range_mask = lane_flag;
  assign out_ch.valid             = vld_r[LAT-1];

  // Flagged lanes always carry the fill pattern; checked here on lane 0
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.out_of_range_mask[0] |-> out_ch.y[0] == vcf_pkg::FLAG_FILL)
    else $error("flagged lane 0 without fill pattern");

  // Nothing comes out right after reset
  a_rst: assert property (@(posedge clk) $past(!rst_n) |-> !out_ch.valid)
    else $error("result valid right after reset");

  // A stall freezes the valid pipeline
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline moved during stall");

  // An accepted item enters the first slot
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> vld_r[0])
    else $error("accepted item lost at entry");

endmodule
